/* hw/rtl/ifhr_pkg.sv */
// ifhr_pkg: shared types, constants and helpers for the ipv4 forward header rewrite block
// no dependencies; imported by every module under hw/rtl
package ifhr_pkg;

    localparam int MAX_HEADER_WORDS = 15;
    localparam int ETH_HW           = 7;
    localparam int STORE_DEPTH      = ETH_HW + 2 * MAX_HEADER_WORDS;
    localparam int POS_W            = $clog2(STORE_DEPTH);
    localparam int IHL_MIN          = 5;
    localparam int ACC_W            = 21;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [15:0]      t_hw;

    // halfword positions inside the buffered header
    localparam t_pos POS_DMAC = t_pos'(0);
    localparam t_pos POS_SMAC = t_pos'(3);
    localparam t_pos POS_IP   = t_pos'(ETH_HW);
    localparam t_pos POS_TTL  = t_pos'(ETH_HW + 4);
    localparam t_pos POS_CSUM = t_pos'(ETH_HW + 5);
    localparam t_pos POS_DSTH = t_pos'(ETH_HW + 8);
    localparam t_pos POS_DSTL = t_pos'(ETH_HW + 9);

    // control states
    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_PASS    = 2'd1;
    localparam logic [1:0] ST_DISCARD = 2'd2;
    localparam logic [1:0] ST_EMIT    = 2'd3;

    // frame status codes
    localparam logic [1:0] STAT_FWD    = 2'd0;
    localparam logic [1:0] STAT_BADLEN = 2'd1;
    localparam logic [1:0] STAT_TRUNC  = 2'd2;

    // register indexes (byte address / 8)
    localparam logic [2:0] REG_HOST_A_ADDR = 3'd0;
    localparam logic [2:0] REG_HOST_B_ADDR = 3'd1;
    localparam logic [2:0] REG_HOST_A_MAC  = 3'd2;
    localparam logic [2:0] REG_HOST_B_MAC  = 3'd3;
    localparam logic [2:0] REG_GW_MAC      = 3'd4;
    localparam logic [2:0] REG_LOCAL_SMAC  = 3'd5;
    localparam logic [2:0] REG_REMOTE_SMAC = 3'd6;

    localparam logic [31:0] RST_HOST_A_ADDR = 32'h0A01_0203;
    localparam logic [31:0] RST_HOST_B_ADDR = 32'h0A01_0204;
    localparam logic [47:0] RST_HOST_A_MAC  = 48'h0015_175D_2988;
    localparam logic [47:0] RST_HOST_B_MAC  = 48'h0015_175D_16B4;
    localparam logic [47:0] RST_GW_MAC      = 48'h0015_175D_29E5;
    localparam logic [47:0] RST_LOCAL_SMAC  = 48'h0015_175D_27E8;
    localparam logic [47:0] RST_REMOTE_SMAC = 48'h0015_175D_27E9;

    typedef struct packed {
        logic [31:0] host_a_addr;
        logic [31:0] host_b_addr;
        logic [47:0] host_a_mac;
        logic [47:0] host_b_mac;
        logic [47:0] gw_mac;
        logic [47:0] local_smac;
        logic [47:0] remote_smac;
    } t_cfg;

    // one of the three halfwords of a mac, first byte on the wire highest
    function automatic t_hw mac_half(input logic [47:0] mac, input logic [1:0] k);
        t_hw h;
        case (k)
            2'd0:    h = mac[47:32];
            2'd1:    h = mac[31:16];
            default: h = mac[15:0];
        endcase
        return h;
    endfunction

    // ones-complement fold of the running sum, inverted
    function automatic t_hw csum_fold(input logic [ACC_W-1:0] acc);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = 17'(acc[ACC_W-1:16]) + 17'(acc[15:0]);
        s2 = s1[15:0] + 16'(s1[16]);
        return ~s2;
    endfunction

endpackage

/* hw/rtl/ipv4_forward_header_rewrite.sv */
// ipv4_forward_header_rewrite: top level, frame sequencer, checksum and output stage
// depends on ifhr_pkg, ifhr_hdr_ram and ifhr_cfg_regs
//
//  channel  | direction | signals                                     | moves
//  ---------+-----------+---------------------------------------------+------------------------
//  s_axis   | in        | tvalid tready tdata[15:0] tlast tuser[0]    | frame halfword
//  m_axis   | out       | tvalid tready tdata[15:0] tlast tuser[3:0]  | rewritten halfword/report
//  apb      | in        | psel penable pwrite paddr pwdata prdata     | config register access
//
// cycles: header halfwords are taken one per cycle and written to the header buffer;
//   when the last header halfword arrives the input stalls while the buffered halfwords
//   are read back through the single read port, one per cycle (the first read is issued
//   before any halfword is emitted); payload then passes at one transfer per cycle
// reset: control state and config registers only; the header buffer needs no clearing
//   since only entries written in the current frame are read
// stalls: a full output register that is not taken stalls input and header readback
module ipv4_forward_header_rewrite
    import ifhr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // frame input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] frame_halfword
    input  logic        s_axis_tlast,   // frame_end
    input  logic        s_axis_tuser,   // [0] low_byte_valid
    // frame output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_halfword
    output logic        m_axis_tlast,   // out_last
    output logic [3:0]  m_axis_tuser,   // [0] out_low_byte_valid, [1] egress_port,
                                        // [3:2] frame_status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;

    ifhr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer state
    logic [1:0]       r_state,   n_state;
    t_pos             r_pos,     n_pos;        // next header halfword position
    t_pos             r_last,    n_last;       // position of the final header halfword
    logic [ACC_W-1:0] r_acc,     n_acc;        // ip header sum, ttl adjusted, csum as zero
    logic [31:0]      r_dst,     n_dst;
    logic             r_fe,      n_fe;         // header ended the frame
    logic             r_port,    n_port;
    t_pos             r_idx,     n_idx;        // readback position
    logic             r_pend,    n_pend;       // read data holds entry r_idx

    // output register
    logic             r_ovalid,  n_ovalid;
    t_hw              r_odata,   n_odata;
    logic             r_olv,     n_olv;
    logic             r_olast,   n_olast;
    logic             r_oport,   n_oport;
    logic [1:0]       r_ostat,   n_ostat;

    // header buffer access; writes only while collecting, reads only while emitting,
    // so no access to the same entry can overlap
    logic             w_we;
    t_hw              w_wdata;
    logic             w_re;
    t_pos             w_raddr;
    t_hw              w_rdata;

    ifhr_hdr_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic       w_ofree;
    logic       w_in_xfer;
    t_hw        w_hw;
    logic [3:0] w_ihl;
    logic       w_bad_ihl;
    logic       w_complete;
    logic       w_trunc;
    t_hw        w_contrib;
    logic       w_route_gw;
    t_hw        w_emit_hw;
    logic       w_emit_end;

    assign w_ofree       = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state != ST_EMIT) && w_ofree;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_hw          = s_axis_tdata;

    // header length check on the first ip halfword
    assign w_ihl      = w_hw[11:8];
    assign w_bad_ihl  = (r_pos == POS_IP) &&
                        ((w_ihl < 4'(IHL_MIN)) || (w_ihl > 4'(MAX_HEADER_WORDS)));
    assign w_complete = (r_pos > POS_IP) && (r_pos == r_last);
    assign w_trunc    = s_axis_tlast && (!w_complete || !s_axis_tuser);

    // ttl is stored already decremented (wraps zero to 255)
    assign w_wdata   = (r_pos == POS_TTL) ? {w_hw[15:8] - 8'd1, w_hw[7:0]} : w_hw;
    assign w_contrib = (r_pos == POS_CSUM) ? 16'd0 : w_wdata;
    assign w_we      = w_in_xfer && (r_state == ST_COLLECT);

    // route lookup: host a first, then host b, else gateway
    assign w_route_gw = (r_dst != w_cfg.host_a_addr) && (r_dst != w_cfg.host_b_addr);

    // rewritten header halfword for readback position r_idx
    always_comb begin
        if (r_idx < POS_SMAC) begin
            w_emit_hw = mac_half(r_port ? w_cfg.gw_mac :
                                 ((r_dst == w_cfg.host_a_addr) ? w_cfg.host_a_mac
                                                               : w_cfg.host_b_mac),
                                 2'(r_idx - POS_DMAC));
        end else if (r_idx < POS_SMAC + t_pos'(3)) begin
            w_emit_hw = mac_half(r_port ? w_cfg.remote_smac : w_cfg.local_smac,
                                 2'(r_idx - POS_SMAC));
        end else if (r_idx == POS_CSUM) begin
            w_emit_hw = csum_fold(r_acc);
        end else begin
            w_emit_hw = w_rdata;
        end
    end

    assign w_emit_end = (r_idx == r_last);

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_last   = r_last;
        n_acc    = r_acc;
        n_dst    = r_dst;
        n_fe     = r_fe;
        n_port   = r_port;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        n_olv    = r_olv;
        n_olast  = r_olast;
        n_oport  = r_oport;
        n_ostat  = r_ostat;
        w_re     = 1'b0;
        w_raddr  = r_idx;

        case (r_state)
            ST_COLLECT: begin
                if (w_in_xfer) begin
                    // running checksum over the ip header
                    if (r_pos == POS_IP) begin
                        n_acc = ACC_W'(w_contrib);
                    end else if (r_pos > POS_IP) begin
                        n_acc = r_acc + ACC_W'(w_contrib);
                    end
                    if (r_pos == POS_IP) begin
                        n_last = t_pos'(ETH_HW - 1) + t_pos'({w_ihl, 1'b0});
                    end
                    if (r_pos == POS_DSTH) begin
                        n_dst[31:16] = w_hw;
                    end
                    if (r_pos == POS_DSTL) begin
                        n_dst[15:0] = w_hw;
                    end

                    if (w_bad_ihl || w_trunc) begin
                        // drop report
                        n_pos    = '0;
                        n_state  = (w_bad_ihl && !s_axis_tlast) ? ST_DISCARD : ST_COLLECT;
                        n_ovalid = 1'b1;
                        n_odata  = '0;
                        n_olv    = 1'b0;
                        n_olast  = 1'b1;
                        n_oport  = 1'b0;
                        n_ostat  = w_bad_ihl ? STAT_BADLEN : STAT_TRUNC;
                    end else if (w_complete) begin
                        n_pos   = '0;
                        n_state = ST_EMIT;
                        n_fe    = s_axis_tlast;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                    end else begin
                        n_pos = r_pos + t_pos'(1);
                    end
                end
            end
            ST_PASS: begin
                if (w_in_xfer) begin
                    n_ovalid = 1'b1;
                    n_odata  = w_hw;
                    n_olv    = s_axis_tuser;
                    n_olast  = s_axis_tlast;
                    n_oport  = r_port;
                    n_ostat  = STAT_FWD;
                    if (s_axis_tlast) begin
                        n_state = ST_COLLECT;
                    end
                end
            end
            ST_DISCARD: begin
                if (w_in_xfer && s_axis_tlast) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                // header readback: keep one read in flight ahead of the output register
                if (!r_pend) begin
                    w_re   = 1'b1;
                    n_pend = 1'b1;
                    if (r_idx == POS_DMAC) begin
                        n_port = w_route_gw;
                    end
                end else if (w_ofree) begin
                    n_ovalid = 1'b1;
                    n_odata  = w_emit_hw;
                    n_olv    = 1'b1;
                    n_olast  = w_emit_end && r_fe;
                    n_oport  = r_port;
                    n_ostat  = STAT_FWD;
                    if (w_emit_end) begin
                        n_pend  = 1'b0;
                        n_state = r_fe ? ST_COLLECT : ST_PASS;
                    end else begin
                        n_idx   = r_idx + t_pos'(1);
                        w_re    = 1'b1;
                        w_raddr = r_idx + t_pos'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_COLLECT;
            r_pos    <= '0;
            r_last   <= '0;
            r_port   <= 1'b0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_last   <= n_last;
            r_port   <= n_port;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_dst   <= n_dst;
        r_fe    <= n_fe;
        r_odata <= n_odata;
        r_olv   <= n_olv;
        r_olast <= n_olast;
        r_oport <= n_oport;
        r_ostat <= n_ostat;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = {r_ostat, r_oport, r_olv};

endmodule

/* hw/rtl/ifhr_hdr_ram.sv */
// ifhr_hdr_ram: header buffer, one write port and one registered read port
// depends on ifhr_pkg for depth and halfword type
module ifhr_hdr_ram
    import ifhr_pkg::*;
(
    input  logic i_clk,
    input  logic i_we,
    input  t_pos i_waddr,
    input  t_hw  i_wdata,
    input  logic i_re,
    input  t_pos i_raddr,
    output t_hw  o_rdata
);

    t_hw r_mem [STORE_DEPTH];
    t_hw r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ifhr_cfg_regs.sv */
// ifhr_cfg_regs: apb register file for host addresses and mac addresses
// depends on ifhr_pkg for the config struct, register indexes and reset values
module ifhr_cfg_regs
    import ifhr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[5:3];
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.host_a_addr <= RST_HOST_A_ADDR;
            r_cfg.host_b_addr <= RST_HOST_B_ADDR;
            r_cfg.host_a_mac  <= RST_HOST_A_MAC;
            r_cfg.host_b_mac  <= RST_HOST_B_MAC;
            r_cfg.gw_mac      <= RST_GW_MAC;
            r_cfg.local_smac  <= RST_LOCAL_SMAC;
            r_cfg.remote_smac <= RST_REMOTE_SMAC;
        end else if (w_wr) begin
            case (w_idx)
                REG_HOST_A_ADDR: r_cfg.host_a_addr <= pwdata[31:0];
                REG_HOST_B_ADDR: r_cfg.host_b_addr <= pwdata[31:0];
                REG_HOST_A_MAC:  r_cfg.host_a_mac  <= pwdata[47:0];
                REG_HOST_B_MAC:  r_cfg.host_b_mac  <= pwdata[47:0];
                REG_GW_MAC:      r_cfg.gw_mac      <= pwdata[47:0];
                REG_LOCAL_SMAC:  r_cfg.local_smac  <= pwdata[47:0];
                REG_REMOTE_SMAC: r_cfg.remote_smac <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_HOST_A_ADDR: prdata = 64'(r_cfg.host_a_addr);
            REG_HOST_B_ADDR: prdata = 64'(r_cfg.host_b_addr);
            REG_HOST_A_MAC:  prdata = 64'(r_cfg.host_a_mac);
            REG_HOST_B_MAC:  prdata = 64'(r_cfg.host_b_mac);
            REG_GW_MAC:      prdata = 64'(r_cfg.gw_mac);
            REG_LOCAL_SMAC:  prdata = 64'(r_cfg.local_smac);
            REG_REMOTE_SMAC: prdata = 64'(r_cfg.remote_smac);
            default:         prdata = 64'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
